### rtl/cna_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cna_pkg: shared types and constants
// Operation codes, default widths and the control word that travels with
// each transaction down the complex ALU pipeline.
// ----------------------------------------------------------------------------
package cna_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic dbz;
    logic re_neg;
    logic im_neg;
  } ctl_t;

endpackage
`default_nettype wire

### rtl/cna_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cna_front: operand products and signed-magnitude forming
// Stage one takes the partial products and the plain sums, stage two forms
// the real and imaginary magnitudes, their signs and the divisor norm.
// ----------------------------------------------------------------------------
module cna_front #(
  parameter int DW = cna_pkg::DATA_WIDTH,
  parameter int FB = cna_pkg::FRAC_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire cna_pkg::cmd_t              in_cmd,
  input  wire logic signed [DW-1:0]       in_a,
  input  wire logic signed [DW-1:0]       in_b,
  input  wire logic signed [DW-1:0]       in_c,
  input  wire logic signed [DW-1:0]       in_d,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output cna_pkg::ctl_t                   out_ctl,
  output logic [2*DW-1:0]                 out_den,
  output logic [2*DW+FB:0]                out_num_re,
  output logic [2*DW+FB:0]                out_num_im
);

  localparam int MW = 2 * DW;
  localparam int SW = MW + FB + 1;

  // stage one
  logic                   v1;
  logic                   r1;
  cna_pkg::cmd_t          cmd1;
  logic                   dbz1;
  logic signed [MW-1:0]   p_ac, p_bd, p_bc, p_ad, p_cc, p_dd;
  logic signed [DW:0]     s_re, s_im;

  // stage two
  logic                   r2;
  logic signed [MW:0]     sum_re, sum_im;
  logic [MW:0]            abs_re, abs_im;

  assign r1       = !v1 || r2;
  assign r2       = !out_valid || out_ready;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
    if (r1 && in_valid) begin
      cmd1 <= in_cmd;
      dbz1 <= (in_cmd == cna_pkg::CMD_DIV) && (in_c == '0) && (in_d == '0);
      p_ac <= in_a * in_c;
      p_bd <= in_b * in_d;
      p_bc <= in_b * in_c;
      p_ad <= in_a * in_d;
      p_cc <= in_c * in_c;
      p_dd <= in_d * in_d;
      if (in_cmd == cna_pkg::CMD_SUB) begin
        s_re <= {in_a[DW-1], in_a} - {in_c[DW-1], in_c};
        s_im <= {in_b[DW-1], in_b} - {in_d[DW-1], in_d};
      end else begin
        s_re <= {in_a[DW-1], in_a} + {in_c[DW-1], in_c};
        s_im <= {in_b[DW-1], in_b} + {in_d[DW-1], in_d};
      end
    end
  end

  always_comb begin
    unique case (cmd1)
      cna_pkg::CMD_ADD, cna_pkg::CMD_SUB: begin
        sum_re = {{(MW-DW){s_re[DW]}}, s_re};
        sum_im = {{(MW-DW){s_im[DW]}}, s_im};
      end
      cna_pkg::CMD_MUL: begin
        sum_re = {p_ac[MW-1], p_ac} - {p_bd[MW-1], p_bd};
        sum_im = {p_bc[MW-1], p_bc} + {p_ad[MW-1], p_ad};
      end
      default: begin
        sum_re = {p_ac[MW-1], p_ac} + {p_bd[MW-1], p_bd};
        sum_im = {p_bc[MW-1], p_bc} - {p_ad[MW-1], p_ad};
      end
    endcase
    abs_re = sum_re[MW] ? -sum_re : sum_re;
    abs_im = sum_im[MW] ? -sum_im : sum_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r2) begin
      out_valid <= v1;
    end
    if (r2 && v1) begin
      out_ctl.cmd    <= cmd1;
      out_ctl.dbz    <= dbz1;
      out_ctl.re_neg <= sum_re[MW];
      out_ctl.im_neg <= sum_im[MW];
      out_den        <= p_cc + p_dd;
      // numerator with room for the fraction and the rounding bit
      out_num_re     <= SW'({abs_re[MW-1:0], {(FB+1){1'b0}}});
      out_num_im     <= SW'({abs_im[MW-1:0], {(FB+1){1'b0}}});
    end
  end

endmodule
`default_nettype wire

### rtl/cna_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cna_div_cell: one restoring-division step
// Shifts one numerator bit into the partial remainder of both parts and
// develops one quotient bit; non-divide transactions shift their magnitude
// straight into the quotient register.
// ----------------------------------------------------------------------------
module cna_div_cell #(
  parameter int MW = 2 * cna_pkg::DATA_WIDTH,
  parameter int SW = 2 * cna_pkg::DATA_WIDTH + cna_pkg::FRAC_BITS + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cna_pkg::ctl_t in_ctl,
  input  wire logic [MW-1:0] in_den,
  input  wire logic [SW-1:0] in_num_re,
  input  wire logic [SW-1:0] in_num_im,
  input  wire logic [MW-1:0] in_rem_re,
  input  wire logic [MW-1:0] in_rem_im,
  input  wire logic [SW-1:0] in_quo_re,
  input  wire logic [SW-1:0] in_quo_im,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cna_pkg::ctl_t      out_ctl,
  output logic [MW-1:0]      out_den,
  output logic [SW-1:0]      out_num_re,
  output logic [SW-1:0]      out_num_im,
  output logic [MW-1:0]      out_rem_re,
  output logic [MW-1:0]      out_rem_im,
  output logic [SW-1:0]      out_quo_re,
  output logic [SW-1:0]      out_quo_im
);

  logic          is_div;
  logic [MW:0]   t_re, t_im;
  logic          ge_re, ge_im;
  logic [MW-1:0] rem_re_next, rem_im_next;
  logic [SW-1:0] quo_re_next, quo_im_next;

  assign in_ready = !out_valid || out_ready;
  assign is_div   = (in_ctl.cmd == cna_pkg::CMD_DIV);

  always_comb begin
    t_re  = {in_rem_re, in_num_re[SW-1]};
    t_im  = {in_rem_im, in_num_im[SW-1]};
    ge_re = t_re >= {1'b0, in_den};
    ge_im = t_im >= {1'b0, in_den};
    rem_re_next = ge_re ? MW'(t_re - {1'b0, in_den}) : t_re[MW-1:0];
    rem_im_next = ge_im ? MW'(t_im - {1'b0, in_den}) : t_im[MW-1:0];
    quo_re_next = {in_quo_re[SW-2:0], is_div ? ge_re : in_num_re[SW-1]};
    quo_im_next = {in_quo_im[SW-2:0], is_div ? ge_im : in_num_im[SW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ctl    <= in_ctl;
      out_den    <= in_den;
      out_num_re <= {in_num_re[SW-2:0], 1'b0};
      out_num_im <= {in_num_im[SW-2:0], 1'b0};
      out_rem_re <= rem_re_next;
      out_rem_im <= rem_im_next;
      out_quo_re <= quo_re_next;
      out_quo_im <= quo_im_next;
    end
  end

endmodule
`default_nettype wire

### rtl/cna_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cna_back: rounding, saturation and output register
// Rounds each part for its operation, clamps it to the output range and
// holds the finished transaction until the sink takes it.
// ----------------------------------------------------------------------------
module cna_back #(
  parameter int DW = cna_pkg::DATA_WIDTH,
  parameter int FB = cna_pkg::FRAC_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cna_pkg::ctl_t       in_ctl,
  input  wire logic [2*DW+FB:0]    in_quo_re,
  input  wire logic [2*DW+FB:0]    in_quo_im,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [DW-1:0]            out_real,
  output logic [DW-1:0]            out_imag,
  output logic                     out_dbz,
  output logic                     out_ovf
);

  localparam int SW = 2 * DW + FB + 1;
  localparam logic [SW:0] LIM_V  = {{(SW-DW+1){1'b0}}, 1'b1, {(DW-1){1'b0}}};
  localparam logic [SW:0] HALF_V = (SW+1)'((2**FB) / 2);

  logic [SW:0]   mag_re, mag_im;
  logic          neg_re, neg_im;
  logic [DW-1:0] sat_re, sat_im;
  logic          ovf_re, ovf_im;

  assign in_ready = !out_valid || out_ready;

  function automatic logic [SW:0] round_mag(cna_pkg::cmd_t cmd, logic [SW-1:0] quo);
    logic [SW:0] plain;
    logic [SW:0] r;
    begin
      plain = {1'b0, quo} >> (FB + 1);
      unique case (cmd)
        cna_pkg::CMD_ADD, cna_pkg::CMD_SUB: r = plain;
        cna_pkg::CMD_MUL:                   r = (plain + HALF_V) >> FB;
        default:                            r = ({1'b0, quo} + (SW+1)'(1)) >> 1;
      endcase
      return r;
    end
  endfunction

  function automatic logic [DW:0] saturate(logic neg, logic [SW:0] mag);
    logic [SW:0] neg_mag;
    begin
      neg_mag = -mag;
      if (!neg) begin
        if (mag > LIM_V - (SW+1)'(1)) begin
          return {1'b1, 1'b0, {(DW-1){1'b1}}};
        end
        return {1'b0, mag[DW-1:0]};
      end
      if (mag > LIM_V) begin
        return {1'b1, 1'b1, {(DW-1){1'b0}}};
      end
      return {1'b0, neg_mag[DW-1:0]};
    end
  endfunction

  always_comb begin
    mag_re = round_mag(in_ctl.cmd, in_quo_re);
    mag_im = round_mag(in_ctl.cmd, in_quo_im);
    neg_re = in_ctl.re_neg;
    neg_im = in_ctl.im_neg;
    // zero divisor: force a clean zero result
    if (in_ctl.dbz) begin
      mag_re = '0;
      mag_im = '0;
      neg_re = 1'b0;
      neg_im = 1'b0;
    end
    {ovf_re, sat_re} = saturate(neg_re, mag_re);
    {ovf_im, sat_im} = saturate(neg_im, mag_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_real <= sat_re;
      out_imag <= sat_im;
      out_dbz  <= in_ctl.dbz;
      out_ovf  <= ovf_re || ovf_im;
    end
  end

endmodule
`default_nettype wire

### rtl/complex_number_alu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_number_alu_core: complex add, subtract, multiply and divide
// Pipeline: front end, one division cell per quotient bit, then the output register.
// Throughput: one transaction per cycle, every operation, while the sink keeps m_axis_tready high.
// Reset: synchronous rst empties every pipeline stage; no stored state otherwise.
// ----------------------------------------------------------------------------
module complex_number_alu_core #(
  parameter int DATA_WIDTH = cna_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = cna_pkg::FRAC_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // left_real, left_imag, right_real, right_imag
  input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // cmd
  input  wire logic [1:0]                            s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // result_real, result_imag
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  // divide_by_zero, overflow
  output logic [1:0]                                 m_axis_tuser
);

  localparam int MW    = 2 * DATA_WIDTH;
  localparam int SW    = MW + FRAC_BITS + 1;
  localparam int OUT_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

  logic                chain_valid  [0:SW];
  logic                chain_ready  [0:SW];
  cna_pkg::ctl_t       chain_ctl    [0:SW];
  logic [MW-1:0]       chain_den    [0:SW];
  logic [SW-1:0]       chain_num_re [0:SW];
  logic [SW-1:0]       chain_num_im [0:SW];
  logic [MW-1:0]       chain_rem_re [0:SW];
  logic [MW-1:0]       chain_rem_im [0:SW];
  logic [SW-1:0]       chain_quo_re [0:SW];
  logic [SW-1:0]       chain_quo_im [0:SW];

  logic [DATA_WIDTH-1:0] res_real, res_imag;
  logic                  res_dbz, res_ovf;

  cna_front #(
    .DW(DATA_WIDTH),
    .FB(FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (cna_pkg::cmd_t'(s_axis_tuser)),
    .in_a       ($signed(s_axis_tdata[DATA_WIDTH-1:0])),
    .in_b       ($signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
    .in_c       ($signed(s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH])),
    .in_d       ($signed(s_axis_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH])),
    .out_valid  (chain_valid[0]),
    .out_ready  (chain_ready[0]),
    .out_ctl    (chain_ctl[0]),
    .out_den    (chain_den[0]),
    .out_num_re (chain_num_re[0]),
    .out_num_im (chain_num_im[0])
  );

  // partial remainder and quotient start empty
  assign chain_rem_re[0] = '0;
  assign chain_rem_im[0] = '0;
  assign chain_quo_re[0] = '0;
  assign chain_quo_im[0] = '0;

  for (genvar i = 0; i < SW; i++) begin : g_cell
    cna_div_cell #(
      .MW(MW),
      .SW(SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (chain_valid[i]),
      .in_ready   (chain_ready[i]),
      .in_ctl     (chain_ctl[i]),
      .in_den     (chain_den[i]),
      .in_num_re  (chain_num_re[i]),
      .in_num_im  (chain_num_im[i]),
      .in_rem_re  (chain_rem_re[i]),
      .in_rem_im  (chain_rem_im[i]),
      .in_quo_re  (chain_quo_re[i]),
      .in_quo_im  (chain_quo_im[i]),
      .out_valid  (chain_valid[i+1]),
      .out_ready  (chain_ready[i+1]),
      .out_ctl    (chain_ctl[i+1]),
      .out_den    (chain_den[i+1]),
      .out_num_re (chain_num_re[i+1]),
      .out_num_im (chain_num_im[i+1]),
      .out_rem_re (chain_rem_re[i+1]),
      .out_rem_im (chain_rem_im[i+1]),
      .out_quo_re (chain_quo_re[i+1]),
      .out_quo_im (chain_quo_im[i+1])
    );
  end

  cna_back #(
    .DW(DATA_WIDTH),
    .FB(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[SW]),
    .in_ready  (chain_ready[SW]),
    .in_ctl    (chain_ctl[SW]),
    .in_quo_re (chain_quo_re[SW]),
    .in_quo_im (chain_quo_im[SW]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_real  (res_real),
    .out_imag  (res_imag),
    .out_dbz   (res_dbz),
    .out_ovf   (res_ovf)
  );

  assign m_axis_tdata = OUT_W'({res_imag, res_real});
  assign m_axis_tuser = {res_ovf, res_dbz};

endmodule
`default_nettype wire

### tb/complex_alu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_alu_checker: result predictor and scoreboard
// Watches both stream channels, computes the expected sum, difference,
// product or quotient of each accepted operand pair and compares it with
// the result transactions in order.
// ----------------------------------------------------------------------------
module complex_alu_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [63:0] in_data,
  input  wire logic [1:0]  in_user,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_data,
  input  wire logic [1:0]  out_user,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic        dbz;
    logic        ovf;
  } cplx_res_t;

  cplx_res_t expected_q[$];

  // Round-to-nearest, ties away from zero, of num / den with num signed.
  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] clamp16(longint v, ref logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic cplx_res_t complex_result(cna_pkg::cmd_t op, logic [63:0] d);
    longint a, b, c, e, re, im, den;
    logic ovf;
    cplx_res_t r;
    a = longint'($signed(d[15:0]));
    b = longint'($signed(d[31:16]));
    c = longint'($signed(d[47:32]));
    e = longint'($signed(d[63:48]));
    ovf = 1'b0;
    r.dbz = 1'b0;
    re = 0;
    im = 0;
    case (op)
      cna_pkg::CMD_ADD: begin
        re = a + c;
        im = b + e;
      end
      cna_pkg::CMD_SUB: begin
        re = a - c;
        im = b - e;
      end
      cna_pkg::CMD_MUL: begin
        re = div_round(a * c - b * e, 256);
        im = div_round(b * c + a * e, 256);
      end
      default: begin
        if (c == 0 && e == 0) begin
          r.dbz = 1'b1;
        end else begin
          den = c * c + e * e;
          re = div_round((a * c + b * e) * 256, den);
          im = div_round((b * c - a * e) * 256, den);
        end
      end
    endcase
    r.re = clamp16(re, ovf);
    r.im = clamp16(im, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    cplx_res_t exp_r;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(complex_result(cna_pkg::cmd_t'(in_user), in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %h %b", out_data, out_user);
          errs = errs + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data[15:0] !== exp_r.re) begin
            $error("result_real expected %h got %h", exp_r.re, out_data[15:0]);
            errs = errs + 1;
          end
          if (out_data[31:16] !== exp_r.im) begin
            $error("result_imag expected %h got %h", exp_r.im, out_data[31:16]);
            errs = errs + 1;
          end
          if (out_user[0] !== exp_r.dbz) begin
            $error("divide_by_zero expected %b got %b", exp_r.dbz, out_user[0]);
            errs = errs + 1;
          end
          if (out_user[1] !== exp_r.ovf) begin
            $error("overflow expected %b got %b", exp_r.ovf, out_user[1]);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= expected_q.size();
    end
  end
endmodule
`default_nettype wire

### tb/tb_complex_number_alu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_complex_number_alu_core: stimulus and verdict for the complex ALU
// Drives directed corner operands and random operand pairs through the
// input stream under changing backpressure; the checker scores results.
// ----------------------------------------------------------------------------
module tb_complex_number_alu_core;

  localparam int LATENCY  = 2 * cna_pkg::DATA_WIDTH + cna_pkg::FRAC_BITS + 4;
  localparam int WD_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          idle_cycles;

  complex_number_alu_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  complex_alu_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_user(s_axis_tuser),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver backpressure.
  always @(posedge clk)
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[complex_number_alu_core] ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(cna_pkg::cmd_t op, logic [15:0] a, logic [15:0] b,
                      logic [15:0] c, logic [15:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {e, c, b, a};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic random_phase(int count, int s_pct, int r_pct);
    logic [15:0] c, e;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) begin
      c = rand_operand();
      e = rand_operand();
      // Keep most divides away from the zero divisor, hit it now and then.
      if ($urandom_range(19) == 0) begin
        c = 16'h0000;
        e = 16'h0000;
      end
      send(cna_pkg::cmd_t'($urandom_range(3)), rand_operand(), rand_operand(), c, e);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = cna_pkg::CMD_ADD;
    m_axis_tready = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 58;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, every operation, saturation, zero divisor.
    send(cna_pkg::CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send(cna_pkg::CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
    send(cna_pkg::CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send(cna_pkg::CMD_SUB, 16'h0200, 16'h0100, 16'h0200, 16'h0100);
    send(cna_pkg::CMD_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
    send(cna_pkg::CMD_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send(cna_pkg::CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    send(cna_pkg::CMD_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000);
    send(cna_pkg::CMD_MUL, 16'hffff, 16'h0000, 16'h0080, 16'h0000);
    send(cna_pkg::CMD_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send(cna_pkg::CMD_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(cna_pkg::CMD_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
    send(cna_pkg::CMD_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send(cna_pkg::CMD_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hffff);
    send(cna_pkg::CMD_DIV, 16'h0100, 16'h0200, 16'h0300, 16'hfd00);
    send(cna_pkg::CMD_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h8000);
    send(cna_pkg::CMD_DIV, 16'h0080, 16'h0000, 16'h0300, 16'h0000);
    random_phase(300, 29, 58);
    random_phase(300, 58, 29);
    random_phase(330, 0, 0);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0)
      $display("[complex_number_alu_core] OK");
    else
      $display("[complex_number_alu_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
